/* design/fisheye_offset_to_angles_assert.svh */
// Assertion macros used by the checker of the fisheye angle converter.
`ifndef FISHEYE_OFFSET_TO_ANGLES_ASSERT_SVH
`define FISHEYE_OFFSET_TO_ANGLES_ASSERT_SVH

// Implication checked at every clock edge outside reset.
`define FOA_ASSERT_IMP(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Plain invariant checked at every clock edge outside reset.
`define FOA_ASSERT_ALWAYS(name, expr, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
        else $error(msg);

`endif

/* design/foa_pkg.sv */
// Shared types and constants of the fisheye offset to angle converter.
`default_nettype none

package foa_pkg;

    // Field widths.
    localparam int COORD_W     = 12;
    localparam int ANGLE_W     = 16;
    localparam int DIST_W      = 14;
    localparam int RADIUS_W    = 12;
    localparam int FOV_W       = 16;
    localparam int CFG_DATA_W  = 16;
    localparam int CFG_INDEX_W = 1;

    // Register indexes.
    localparam logic [CFG_INDEX_W-1:0] CFG_LENS_RADIUS = 1'b0;
    localparam logic [CFG_INDEX_W-1:0] CFG_LENS_FOV    = 1'b1;

    // Register reset values.
    localparam logic [RADIUS_W-1:0] RADIUS_RESET = 12'd1024;
    localparam logic [FOV_W-1:0]    FOV_RESET    = 16'd25736;

    // Internal angle format and CORDIC constants.
    localparam int          ANGLE_INT_FRAC = 30;
    localparam int          ATAN_TAB_LEN   = 24;
    localparam int          PRE_SHIFT      = 16;
    localparam logic [31:0] PI_Q30         = 32'd3373259426;

    // Distance and elevation datapath sizes.
    // The distance path has seven registers beside the root and divider stages:
    // squares, sum, rounded distance, product, dividend, divider setup, output.
    localparam int SQ_W       = 2 * COORD_W;
    localparam int RAD_W      = SQ_W + 6;
    localparam int SQRT_STEPS = RAD_W / 2;
    localparam int NUM_W      = DIST_W + FOV_W + 1;
    localparam int DEN_W      = RADIUS_W + 3;
    localparam int DIV_STEPS  = NUM_W - 3;
    localparam int DIST_LAT   = SQRT_STEPS + DIV_STEPS + 7;

    localparam logic [DIST_W-1:0] DIST_MAX = 14'd11586;

    typedef struct packed {
        logic signed [COORD_W-1:0] offset_x;
        logic signed [COORD_W-1:0] offset_y;
    } foa_in_t;

    typedef struct packed {
        logic        [ANGLE_W-1:0] azimuth;
        logic signed [ANGLE_W-1:0] elevation;
        logic        [DIST_W-1:0]  radial_distance;
    } foa_out_t;

    // atan(2^-i) in Q30, rounded to nearest.
    function automatic logic [29:0] atan_q30(input logic [4:0] idx);
        logic [29:0] val;
        unique case (idx)
            5'd0:    val = 30'd843314857;
            5'd1:    val = 30'd497837829;
            5'd2:    val = 30'd263043837;
            5'd3:    val = 30'd133525159;
            5'd4:    val = 30'd67021687;
            5'd5:    val = 30'd33543516;
            5'd6:    val = 30'd16775851;
            5'd7:    val = 30'd8388437;
            5'd8:    val = 30'd4194283;
            5'd9:    val = 30'd2097149;
            5'd10:   val = 30'd1048576;
            5'd11:   val = 30'd524288;
            5'd12:   val = 30'd262144;
            5'd13:   val = 30'd131072;
            5'd14:   val = 30'd65536;
            5'd15:   val = 30'd32768;
            5'd16:   val = 30'd16384;
            5'd17:   val = 30'd8192;
            5'd18:   val = 30'd4096;
            5'd19:   val = 30'd2048;
            5'd20:   val = 30'd1024;
            5'd21:   val = 30'd512;
            5'd22:   val = 30'd256;
            5'd23:   val = 30'd128;
            default: val = 30'd0;
        endcase
        return val;
    endfunction

endpackage

`default_nettype wire

/* design/foa_cordic.sv */
// Pipelined CORDIC vectoring unit that turns an offset into the wrapped azimuth.
`default_nettype none

module foa_cordic
    import foa_pkg::*;
#(
    parameter int ANGLE_FRAC_BITS = 13,
    parameter int CORDIC_STAGES   = 16
)
(
    input  logic                      clk,
    input  logic signed [COORD_W-1:0] x,
    input  logic signed [COORD_W-1:0] y,
    output logic [ANGLE_W-1:0]        azimuth
);

    localparam int N_ST  = (CORDIC_STAGES < ATAN_TAB_LEN) ? CORDIC_STAGES : ATAN_TAB_LEN;
    localparam int UV_W  = COORD_W + PRE_SHIFT + 3;
    localparam int Z_W   = 35;
    localparam int RND_S = ANGLE_INT_FRAC - ANGLE_FRAC_BITS;

    localparam longint PI_L   = longint'(PI_Q30);
    localparam longint HALF_L = longint'(1) << (RND_S - 1);

    localparam logic signed [Z_W-1:0] PI_Z     = Z_W'(PI_L);
    localparam logic signed [Z_W-1:0] TWO_PI_Z = Z_W'(2 * PI_L);
    localparam logic signed [Z_W-1:0] RND_HALF = Z_W'(HALF_L);
    localparam logic signed [Z_W-1:0] FULL_Z   = Z_W'((2 * PI_L + HALF_L) >>> RND_S);

    // The datapath runs free; the distance pipeline carries the valid bits.
    logic signed [UV_W-1:0] u_reg      [N_ST];
    logic signed [UV_W-1:0] v_reg      [N_ST];
    logic signed [Z_W-1:0]  z_reg      [N_ST+1];
    logic                   origin_reg [N_ST+1];

    logic signed [Z_W-1:0] zw_reg;
    logic                  origin_w_reg;
    logic [ANGLE_W-1:0]    az_reg;

    logic signed [UV_W-1:0] x_sc;
    logic signed [UV_W-1:0] y_sc;
    logic signed [Z_W-1:0]  z_round;
    logic signed [Z_W-1:0]  z_wrap;

    assign x_sc = UV_W'(x) <<< PRE_SHIFT;
    assign y_sc = UV_W'(y) <<< PRE_SHIFT;

    // Round to the output format and fold a full turn back to zero.
    always_comb
    begin
        z_round = (zw_reg + RND_HALF) >>> RND_S;
        z_wrap  = (z_round >= FULL_Z) ? z_round - FULL_Z : z_round;
    end

    // Pre-rotation into the right half plane, then one micro-rotation per stage.
    always_ff @(posedge clk)
    begin
        if (y_sc[UV_W-1])
        begin
            u_reg[0] <= -y_sc;
            v_reg[0] <= -x_sc;
            z_reg[0] <= PI_Z;
        end
        else
        begin
            u_reg[0] <= y_sc;
            v_reg[0] <= x_sc;
            z_reg[0] <= '0;
        end
        origin_reg[0] <= (x == '0) && (y == '0);

        for (int k = 0; k < N_ST; k++)
        begin
            if (!v_reg[k][UV_W-1])
                z_reg[k+1] <= z_reg[k] + Z_W'(atan_q30(5'(k)));
            else
                z_reg[k+1] <= z_reg[k] - Z_W'(atan_q30(5'(k)));
            origin_reg[k+1] <= origin_reg[k];
        end

        for (int k = 0; k < N_ST - 1; k++)
        begin
            if (!v_reg[k][UV_W-1])
            begin
                u_reg[k+1] <= u_reg[k] + (v_reg[k] >>> k);
                v_reg[k+1] <= v_reg[k] - (u_reg[k] >>> k);
            end
            else
            begin
                u_reg[k+1] <= u_reg[k] - (v_reg[k] >>> k);
                v_reg[k+1] <= v_reg[k] + (u_reg[k] >>> k);
            end
        end

        // Negative angles move up by a full turn.
        zw_reg       <= z_reg[N_ST][Z_W-1] ? z_reg[N_ST] + TWO_PI_Z : z_reg[N_ST];
        origin_w_reg <= origin_reg[N_ST];

        // The azimuth at the origin is defined as zero.
        az_reg <= origin_w_reg ? '0 : ANGLE_W'(z_wrap);
    end

    assign azimuth = az_reg;

endmodule

`default_nettype wire

/* design/foa_dist.sv */
// Pipelined distance, square root and elevation divider of the angle converter.
`default_nettype none

module foa_dist
    import foa_pkg::*;
#(
    parameter int ANGLE_FRAC_BITS = 13
)
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    input  logic signed [COORD_W-1:0]  x,
    input  logic signed [COORD_W-1:0]  y,
    input  logic [RADIUS_W-1:0]        radius,
    input  logic [FOV_W-1:0]           fov,
    output logic                       out_valid,
    output logic signed [ANGLE_W-1:0]  elevation,
    output logic [DIST_W-1:0]          radial_distance
);

    localparam int RND_S = ANGLE_INT_FRAC - ANGLE_FRAC_BITS;
    localparam int EL_W  = DIV_STEPS + 2;
    localparam int PR_W  = DIST_W + FOV_W;

    localparam longint PI_L       = longint'(PI_Q30);
    localparam longint HALF_L     = longint'(1) << (RND_S - 1);
    localparam longint PI_OUT_L   = (PI_L + HALF_L) >>> RND_S;
    localparam longint HALFPI_L   = (PI_L / 2 + HALF_L) >>> RND_S;

    localparam logic signed [EL_W-1:0] HALFPI_EL = EL_W'(HALFPI_L);
    localparam logic signed [EL_W-1:0] NEG_PI_EL = EL_W'(-PI_OUT_L);

    // Valid bits, one per pipeline register.
    logic valid_reg [DIST_LAT];

    // Squares and their sum.
    logic [SQ_W-2:0] xsq_reg;
    logic [SQ_W-2:0] ysq_reg;
    logic [SQ_W-1:0] sq_reg;
    logic signed [SQ_W-1:0] xx;
    logic signed [SQ_W-1:0] yy;

    // Digit-by-digit square root, two radicand bits per stage.
    logic [RAD_W-1:0] n_reg [SQRT_STEPS];
    logic [RAD_W-1:0] r_reg [SQRT_STEPS+1];

    // Rounded distance, product and dividend.
    logic [DIST_W-1:0] d_reg;
    logic [DIST_W-1:0] d_mul_reg;
    logic [DIST_W-1:0] d_num_reg;
    logic [PR_W-1:0]   prod_reg;
    logic [NUM_W-1:0]  num_reg;
    logic [DIST_W:0]   r_plus;

    // Restoring divider, one quotient bit per stage.
    logic [DEN_W-1:0]     rem_reg  [DIV_STEPS];
    logic [DIV_STEPS-1:0] rest_reg [DIV_STEPS];
    logic [DIV_STEPS-1:0] q_reg    [DIV_STEPS+1];
    logic [DIST_W-1:0]    d_div_reg [DIV_STEPS+1];
    logic [DEN_W-1:0]     den;
    logic [DEN_W:0]       trial    [DIV_STEPS];

    logic signed [EL_W-1:0]   elev_raw;
    logic signed [ANGLE_W-1:0] elev_reg;
    logic [DIST_W-1:0]        dist_reg;

    assign xx     = x * x;
    assign yy     = y * y;
    assign den    = {radius, 3'b000};
    assign r_plus = r_reg[SQRT_STEPS][DIST_W:0] + 1'b1;

    // Partial remainders with the next dividend bit shifted in.
    always_comb
    begin
        for (int t = 0; t < DIV_STEPS; t++)
            trial[t] = {rem_reg[t], rest_reg[t][DIV_STEPS-1]};
    end

    assign elev_raw = HALFPI_EL - EL_W'(q_reg[DIV_STEPS]);

    // Valid chain.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < DIST_LAT; i++)
                valid_reg[i] <= 1'b0;
        end
        else
        begin
            valid_reg[0] <= in_valid;
            for (int i = 1; i < DIST_LAT; i++)
                valid_reg[i] <= valid_reg[i-1];
        end
    end

    // Payload pipeline.
    always_ff @(posedge clk)
    begin
        xsq_reg <= xx[SQ_W-2:0];
        ysq_reg <= yy[SQ_W-2:0];
        sq_reg  <= SQ_W'(xsq_reg) + SQ_W'(ysq_reg);

        // Square root of 64 times the squared norm.
        for (int j = 0; j < SQRT_STEPS; j++)
        begin
            logic [RAD_W-1:0] bitv;
            logic [RAD_W-1:0] n_in;
            logic [RAD_W-1:0] r_in;
            logic [RAD_W-1:0] cand;
            bitv = RAD_W'(1) << (RAD_W - 2 - 2 * j);
            n_in = (j == 0) ? {sq_reg, 6'b000000} : n_reg[(j == 0) ? 0 : j - 1];
            r_in = (j == 0) ? '0 : r_reg[j];
            cand = r_in + bitv;
            if (n_in >= cand)
            begin
                if (j < SQRT_STEPS - 1)
                    n_reg[j] <= n_in - cand;
                r_reg[j+1] <= (r_in >> 1) + bitv;
            end
            else
            begin
                if (j < SQRT_STEPS - 1)
                    n_reg[j] <= n_in;
                r_reg[j+1] <= r_in >> 1;
            end
        end

        // Halve with rounding to get two fraction bits.
        d_reg     <= r_plus[DIST_W:1];
        prod_reg  <= PR_W'(d_reg) * PR_W'(fov);
        d_mul_reg <= d_reg;
        num_reg   <= NUM_W'(prod_reg) + NUM_W'({radius, 2'b00});
        d_num_reg <= d_mul_reg;

        // The divisor is at least eight, so the top three quotient bits are zero.
        rem_reg[0]   <= DEN_W'(num_reg[NUM_W-1:NUM_W-3]);
        rest_reg[0]  <= num_reg[NUM_W-4:0];
        q_reg[0]     <= '0;
        d_div_reg[0] <= d_num_reg;

        for (int t = 0; t < DIV_STEPS; t++)
        begin
            if (trial[t] >= {1'b0, den})
            begin
                if (t < DIV_STEPS - 1)
                    rem_reg[t+1] <= DEN_W'(trial[t] - {1'b0, den});
                q_reg[t+1] <= {q_reg[t][DIV_STEPS-2:0], 1'b1};
            end
            else
            begin
                if (t < DIV_STEPS - 1)
                    rem_reg[t+1] <= DEN_W'(trial[t]);
                q_reg[t+1] <= {q_reg[t][DIV_STEPS-2:0], 1'b0};
            end
            if (t < DIV_STEPS - 1)
                rest_reg[t+1] <= {rest_reg[t][DIV_STEPS-2:0], 1'b0};
            d_div_reg[t+1] <= d_div_reg[t];
        end

        // Elevation never exceeds pi/2, so only the lower clamp can act.
        elev_reg <= (elev_raw < NEG_PI_EL) ? ANGLE_W'(NEG_PI_EL) : ANGLE_W'(elev_raw);
        dist_reg <= d_div_reg[DIV_STEPS];
    end

    assign out_valid       = valid_reg[DIST_LAT-1];
    assign elevation       = elev_reg;
    assign radial_distance = dist_reg;

endmodule

`default_nettype wire

/* design/fisheye_offset_to_angles.sv */
// Top level of the fisheye pixel offset to spherical angle converter.
`default_nettype none

// Converts a signed pixel offset from the fisheye center into azimuth,
// elevation and radial distance. One transaction is taken in every clock
// cycle and busy never rises. Each result appears on the result port for a
// single cycle, marked by done; when it appears is set by the square root
// stages and the bit-per-stage divider of the elevation path, and the CORDIC
// azimuth is delayed to line up with it.
// The receiver cannot stall: a result must be taken in the cycle it shows.
// Lens registers are written through the cfg port; the user must write them
// only while no transaction is in flight, as the block does not enforce it.

module fisheye_offset_to_angles
    import foa_pkg::*;
#(
    parameter int ANGLE_FRAC_BITS = 13,
    parameter int CORDIC_STAGES   = 16
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   start,
    output logic                   busy,
    input  logic                   cfg_we,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_wdata,
    input  foa_in_t                offset,
    output logic                   done,
    output foa_out_t               result
);

    localparam int N_ST     = (CORDIC_STAGES < ATAN_TAB_LEN) ? CORDIC_STAGES : ATAN_TAB_LEN;
    localparam int AZ_DELAY = DIST_LAT - (N_ST + 3);

    logic [RADIUS_W-1:0] radius_reg;
    logic [FOV_W-1:0]    fov_reg;
    logic [RADIUS_W-1:0] radius_eff;

    logic [ANGLE_W-1:0]        az;
    logic [ANGLE_W-1:0]        az_dly_reg [AZ_DELAY];
    logic signed [ANGLE_W-1:0] elevation;
    logic [DIST_W-1:0]         radial_distance;
    logic                      dist_valid;

    // Lens registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            radius_reg <= RADIUS_RESET;
            fov_reg    <= FOV_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_LENS_RADIUS: radius_reg <= cfg_wdata[RADIUS_W-1:0];
                CFG_LENS_FOV:    fov_reg    <= cfg_wdata[FOV_W-1:0];
            endcase
        end
    end

    // A zero radius is treated as one pixel.
    assign radius_eff = (radius_reg == '0) ? RADIUS_W'(1) : radius_reg;

    assign busy = 1'b0;

    foa_cordic #(
        .ANGLE_FRAC_BITS (ANGLE_FRAC_BITS),
        .CORDIC_STAGES   (CORDIC_STAGES)
    ) u_cordic (
        .clk     (clk),
        .x       (offset.offset_x),
        .y       (offset.offset_y),
        .azimuth (az)
    );

    foa_dist #(
        .ANGLE_FRAC_BITS (ANGLE_FRAC_BITS)
    ) u_dist (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (start),
        .x               (offset.offset_x),
        .y               (offset.offset_y),
        .radius          (radius_eff),
        .fov             (fov_reg),
        .out_valid       (dist_valid),
        .elevation       (elevation),
        .radial_distance (radial_distance)
    );

    // Align the azimuth with the longer distance path.
    always_ff @(posedge clk)
    begin
        az_dly_reg[0] <= az;
        for (int i = 1; i < AZ_DELAY; i++)
            az_dly_reg[i] <= az_dly_reg[i-1];
    end

    assign done                   = dist_valid;
    assign result.azimuth         = az_dly_reg[AZ_DELAY-1];
    assign result.elevation       = elevation;
    assign result.radial_distance = radial_distance;

endmodule

`default_nettype wire

/* design/foa_checker.sv */
// Port-level assertion checker for the fisheye angle converter, with its bind.
`default_nettype none

`include "fisheye_offset_to_angles_assert.svh"

module foa_checker
    import foa_pkg::*;
(
    input logic     clk,
    input logic     rst_n,
    input logic     start,
    input logic     busy,
    input logic     done,
    input foa_out_t result
);

    // Every accepted transaction yields exactly one result at the fixed latency.
    `FOA_ASSERT_IMP(a_start_gives_done, start && !busy, ##DIST_LAT done, "result missing")
    `FOA_ASSERT_IMP(a_done_has_start, done, $past(start && !busy, DIST_LAT), "spurious result")

    // Zero distance only happens at the origin, where the azimuth is zero.
    `FOA_ASSERT_IMP(a_origin_azimuth, done && (result.radial_distance == '0),
                    result.azimuth == '0, "nonzero azimuth at origin")

    // The distance never exceeds the corner of the coordinate range.
    `FOA_ASSERT_ALWAYS(a_dist_range, !done || (result.radial_distance <= DIST_MAX),
                       "distance out of range")

endmodule

bind fisheye_offset_to_angles foa_checker u_foa_checker (.*);

`default_nettype wire
